>>> rtl/hex_to_base64_stream_unit_defines.svh
// Assertion macros shared by the checker files of the hex to base64 unit.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HEX_TO_BASE64_STREAM_UNIT_DEFINES_SVH
`define HEX_TO_BASE64_STREAM_UNIT_DEFINES_SVH

// Checks that prop holds at every clock edge outside reset.
`define H2B_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that when trig holds, then cons holds at the next clock edge.
`define H2B_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/h2b_pkg.sv
// ----------------------------------------------------------------------------
// h2b_pkg: shared types and helpers for the hex to base64 unit
// Holds the group record that passes from the front end to the back end,
// the hex digit decoder and the base64 alphabet.
// ----------------------------------------------------------------------------
package h2b_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [1:0] LAST_IDX = 2'd3;
    localparam logic [1:0] PAD2_IDX = 2'd2;

    // One group of four output characters, still as 6-bit codes.
    typedef struct packed {
        logic [5:0] c0;
        logic [5:0] c1;
        logic [5:0] c2;
        logic [5:0] c3;
        logic       pad2;   // third character is '='
        logic       pad3;   // fourth character is '='
        logic       last;   // fourth character ends the stream
    } grp_t;

    // Converts an ASCII hex digit to its nibble; any other code gives zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    // Maps a 6-bit code to the standard base64 alphabet.
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] s;
        if (v < 6'd26) begin
            s = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            s = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62) begin
            s = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62) begin
            s = 8'h2B;
        end
        else begin
            s = 8'h2F;
        end
        return s;
    endfunction

endpackage

>>> rtl/h2b_front.sv
// ----------------------------------------------------------------------------
// h2b_front: character intake and byte grouping
// Decodes hex characters, pairs nibbles into bytes and releases one group
// record for every three bytes or at the end of the stream.
// ----------------------------------------------------------------------------
module h2b_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    hex_char,
    input  logic          last_in,
    input  logic          push,
    input  logic          q_full,
    output logic          grp_push,
    output h2b_pkg::grp_t grp_data
);

    logic [3:0] pending_reg, pending_next;
    logic       held_reg, held_next;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte1_reg, byte1_next;
    logic [1:0] count_reg, count_next;

    logic [3:0] nib;
    logic       accept;
    logic       completes;
    logic       full_grp;
    logic [7:0] byte_val;
    logic [7:0] b0, b1, b2;

    assign nib       = h2b_pkg::nibble_of(hex_char);
    assign accept    = push && !q_full;
    assign byte_val  = held_reg ? {pending_reg, nib} : {nib, 4'h0};
    assign completes = accept && (held_reg || last_in);
    assign full_grp  = (count_reg == 2'd2);
    assign grp_push  = completes && (full_grp || last_in);

    // Operands of the group; bytes that do not exist read as zero.
    always_comb begin
        case (count_reg)
            2'd0: begin
                b0 = byte_val;
                b1 = 8'h00;
                b2 = 8'h00;
            end
            2'd1: begin
                b0 = byte0_reg;
                b1 = byte_val;
                b2 = 8'h00;
            end
            default: begin
                b0 = byte0_reg;
                b1 = byte1_reg;
                b2 = byte_val;
            end
        endcase
    end

    always_comb begin
        grp_data.c0   = b0[7:2];
        grp_data.c1   = {b0[1:0], b1[7:4]};
        grp_data.c2   = {b1[3:0], b2[7:6]};
        grp_data.c3   = b2[5:0];
        grp_data.pad2 = (count_reg == 2'd0);
        grp_data.pad3 = !full_grp;
        grp_data.last = last_in;
    end

    always_comb begin
        pending_next = pending_reg;
        held_next    = held_reg;
        byte0_next   = byte0_reg;
        byte1_next   = byte1_reg;
        count_next   = count_reg;
        if (accept) begin
            if (!held_reg && !last_in) begin
                pending_next = nib;
                held_next    = 1'b1;
            end
            else begin
                pending_next = 4'h0;
                held_next    = 1'b0;
                if (full_grp || last_in) begin
                    count_next = 2'd0;
                end
                else begin
                    if (count_reg[0]) begin
                        byte1_next = byte_val;
                    end
                    else begin
                        byte0_next = byte_val;
                    end
                    count_next = count_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pending_reg <= 4'h0;
            held_reg    <= 1'b0;
            byte0_reg   <= 8'h00;
            byte1_reg   <= 8'h00;
            count_reg   <= 2'd0;
        end
        else begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            byte0_reg   <= byte0_next;
            byte1_reg   <= byte1_next;
            count_reg   <= count_next;
        end
    end

endmodule

>>> rtl/h2b_fifo.sv
// ----------------------------------------------------------------------------
// h2b_fifo: group record queue
// A short first-in first-out queue that decouples intake from output.
// ----------------------------------------------------------------------------
module h2b_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  h2b_pkg::grp_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output h2b_pkg::grp_t rd_data,
    output logic          empty
);

    h2b_pkg::grp_t mem_reg [h2b_pkg::FIFO_DEPTH];

    logic [h2b_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [h2b_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [h2b_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic                        do_wr, do_rd;

    assign full    = (cnt_reg == (h2b_pkg::FIFO_AW+1)'(h2b_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = wr_ptr_reg + (h2b_pkg::FIFO_AW)'(1);
        end
        if (do_rd) begin
            rd_ptr_next = rd_ptr_reg + (h2b_pkg::FIFO_AW)'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + (h2b_pkg::FIFO_AW+1)'(1);
        end
        else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - (h2b_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/h2b_back.sv
// ----------------------------------------------------------------------------
// h2b_back: character serializer
// Takes one group record at a time and presents its four characters, one
// per beat, from an output register.
// ----------------------------------------------------------------------------
module h2b_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  h2b_pkg::grp_t q_data,
    output logic          q_rd,
    input  logic          pop,
    output logic [7:0]    b64_char,
    output logic          last_out,
    output logic          empty
);

    h2b_pkg::grp_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    logic          advance;
    logic          emit;
    logic          grp_done;
    logic [5:0]    code;
    logic [7:0]    char_val;

    assign advance  = !out_valid_reg || pop;
    assign emit     = advance && cur_valid_reg;
    assign grp_done = emit && (idx_reg == h2b_pkg::LAST_IDX);
    assign q_rd     = !q_empty && (!cur_valid_reg || grp_done);

    always_comb begin
        case (idx_reg)
            2'd0:    code = cur_reg.c0;
            2'd1:    code = cur_reg.c1;
            2'd2:    code = cur_reg.c2;
            default: code = cur_reg.c3;
        endcase
    end

    always_comb begin
        if ((idx_reg == h2b_pkg::PAD2_IDX && cur_reg.pad2) ||
            (idx_reg == h2b_pkg::LAST_IDX && cur_reg.pad3)) begin
            char_val = h2b_pkg::PAD_CHAR;
        end
        else begin
            char_val = h2b_pkg::b64_sym(code);
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
        end
        else if (advance) begin
            out_valid_next = 1'b0;
        end
        if (q_rd) begin
            cur_valid_next = 1'b1;
        end
        else if (grp_done) begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (q_rd) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            out_char_reg <= char_val;
            out_last_reg <= cur_reg.last && (idx_reg == h2b_pkg::LAST_IDX);
        end
    end

    assign b64_char = out_char_reg;
    assign last_out = out_last_reg;
    assign empty    = !out_valid_reg;

endmodule

>>> rtl/hex_to_base64_stream_unit.sv
// ----------------------------------------------------------------------------
// hex_to_base64_stream_unit: streaming hex to base64 encoder
// Turns a stream of ASCII hex characters into standard base64 text.
// ----------------------------------------------------------------------------
// The unit takes one ASCII hex character per beat on the input queue port
// (push/full) and accepts a new character in every cycle while full is low.
// Characters other than 0-9, a-f and A-F count as nibble zero. Two nibbles
// make a byte, high nibble first, and every three bytes yield four base64
// characters, delivered one per beat on the output queue port (empty/pop).
// A beat with last_in high ends the stream: a lone high nibble is finished
// with a zero low nibble, one or two leftover bytes give a final group padded
// with '=', and last_out marks the final character of the encoded stream.
// The next character after that starts a fresh stream. The front end packs
// each finished group into a record and writes it to a four-entry queue; the
// back end reads one record at a time and sends its four characters in turn
// from an output register. A completed group passes through the queue, the
// current-group register and the output register before its first character
// shows on the output port. Input throughput is one character per cycle as
// long as the output keeps up, since six hex characters make only four
// output characters; the output serializer, at one character per cycle while
// pop is high, sets the limit when streams are very short and mostly padding,
// and full rises once four group records are waiting.
// ----------------------------------------------------------------------------
module hex_to_base64_stream_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] hex_char,
    input  logic       last_in,
    input  logic       push,
    output logic       full,
    output logic [7:0] b64_char,
    output logic       last_out,
    output logic       empty,
    input  logic       pop
);

    // Group records travel from intake to serializer through the queue.
    logic          grp_push;
    h2b_pkg::grp_t grp_wr;
    h2b_pkg::grp_t grp_rd;
    logic          q_full;
    logic          q_empty;
    logic          q_rd;

    // The intake stalls whenever the queue is full, so no group is ever lost.
    assign full = q_full;

    h2b_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .hex_char (hex_char),
        .last_in  (last_in),
        .push     (push),
        .q_full   (q_full),
        .grp_push (grp_push),
        .grp_data (grp_wr)
    );

    h2b_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_push),
        .wr_data (grp_wr),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (grp_rd),
        .empty   (q_empty)
    );

    h2b_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (grp_rd),
        .q_rd     (q_rd),
        .pop      (pop),
        .b64_char (b64_char),
        .last_out (last_out),
        .empty    (empty)
    );

endmodule

>>> rtl/h2b_checker.sv
// ----------------------------------------------------------------------------
// h2b_checker: port-level checks for the hex to base64 unit
// Watches the output queue port and checks ordering and character rules.
// ----------------------------------------------------------------------------
`include "hex_to_base64_stream_unit_defines.svh"

module h2b_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] b64_char,
    input logic       last_out,
    input logic       empty,
    input logic       pop
);

    // A waiting beat that is not taken stays the same.
    `H2B_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(b64_char) && $stable(last_out), "output beat changed while stalled")

    // Every delivered character is from the base64 alphabet or is padding.
    `H2B_ASSERT_ALWAYS(a_char_legal, empty || (b64_char >= 8'h41 && b64_char <= 8'h5A) || (b64_char >= 8'h61 && b64_char <= 8'h7A) || (b64_char >= 8'h30 && b64_char <= 8'h39) || b64_char == 8'h2B || b64_char == 8'h2F || b64_char == 8'h3D, "illegal output character")

    // Once the first of two padding characters is taken, the second is ready at once.
    `H2B_ASSERT_NEXT(a_pad_follow, !empty && pop && b64_char == 8'h3D && !last_out, !empty && b64_char == 8'h3D && last_out, "padding not followed by final padding")

endmodule

bind hex_to_base64_stream_unit h2b_checker u_h2b_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .b64_char (b64_char),
    .last_out (last_out),
    .empty    (empty),
    .pop      (pop)
);

>>> tb/sv/hex_to_base64_stream_unit_tb.sv
// ----------------------------------------------------------------------------
// hex_to_base64_stream_unit_tb: self-checking bench for the hex to base64 unit
// Streams of ASCII hex characters go in through the push/full port. Every
// base64 character that comes out through the empty/pop port is checked
// against a local encoder. The sender and receiver both idle at random.
// ----------------------------------------------------------------------------
module hex_to_base64_stream_unit_tb;

    // One input beat: a hex character and its end-of-stream flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } hex_beat_t;

    // One output beat: a base64 character and its end-of-stream flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } b64_beat_t;

    // Receiver stall patterns; each one is held for a random stretch.
    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_MOSTLY
    } pop_mode_t;

    localparam int RANDOM_ITEMS = 146;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic [7:0] hex_char = 8'h00;
    logic       last_in  = 1'b0;
    logic       push     = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic [7:0] b64_char;
    logic       last_out;
    logic       empty;

    hex_to_base64_stream_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .hex_char (hex_char),
        .last_in  (last_in),
        .push     (push),
        .full     (full),
        .b64_char (b64_char),
        .last_out (last_out),
        .empty    (empty),
        .pop      (pop)
    );

    always #10 clk = ~clk;

    // Characters waiting to be sent, and base64 beats the encoder expects.
    hex_beat_t hex_pending[$];
    b64_beat_t b64_expected[$];

    int mismatch_count = 0;
    int hex_accepted   = 0;

    // The receiver honors this flag; a separate process raises it once to
    // let the unit fill up while the sender keeps offering beats.
    logic hold_off = 1'b0;

    // Set at the rising edge when an input beat was taken, so that the
    // driver knows whether the beat it is offering has gone through.
    logic beat_taken = 1'b0;

    // Local copy of the encoder state.
    logic [3:0] enc_high_nib  = 4'h0;
    logic       enc_nib_valid = 1'b0;
    logic [7:0] enc_group[0:1] = '{8'h00, 8'h00};
    logic [1:0] enc_group_cnt = 2'd0;

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string hex_digits = "0123456789abcdefABCDEF";

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // Anything outside 0-9, a-f and A-F decodes to zero, with no error.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] b64_symbol(input logic [5:0] code);
        return b64_alphabet[code];
    endfunction

    task automatic expect_b64(input logic [7:0] ch, input logic lst);
        b64_beat_t beat;
        beat.ch   = ch;
        beat.last = lst;
        b64_expected.push_back(beat);
    endtask

    // Feeds one accepted hex character into the model and queues the base64
    // characters it releases.
    task automatic encode_hex_char(input logic [7:0] c, input logic lst);
        logic [3:0] nib;
        logic [7:0] byte_val;
        logic [7:0] b0;
        logic [7:0] b1;
        nib = hex_value(c);
        if (!enc_nib_valid && !lst)
        begin
            enc_high_nib  = nib;
            enc_nib_valid = 1'b1;
        end
        else
        begin
            // A last character with no nibble held becomes a high nibble
            // whose low nibble is zero.
            byte_val      = enc_nib_valid ? {enc_high_nib, nib} : {nib, 4'h0};
            enc_nib_valid = 1'b0;
            enc_high_nib  = 4'h0;
            if (enc_group_cnt == 2'd2)
            begin
                b0 = enc_group[0];
                b1 = enc_group[1];
                expect_b64(b64_symbol(b0[7:2]), 1'b0);
                expect_b64(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
                expect_b64(b64_symbol({b1[3:0], byte_val[7:6]}), 1'b0);
                expect_b64(b64_symbol(byte_val[5:0]), lst);
                enc_group_cnt = 2'd0;
                enc_group[0]  = 8'h00;
                enc_group[1]  = 8'h00;
            end
            else
            begin
                enc_group[enc_group_cnt[0]] = byte_val;
                enc_group_cnt = enc_group_cnt + 2'd1;
                if (lst)
                begin
                    // Padded final group for one or two leftover bytes.
                    b0 = enc_group[0];
                    b1 = enc_group[1];
                    expect_b64(b64_symbol(b0[7:2]), 1'b0);
                    if (enc_group_cnt == 2'd1)
                    begin
                        expect_b64(b64_symbol({b0[1:0], 4'h0}), 1'b0);
                        expect_b64(h2b_pkg::PAD_CHAR, 1'b0);
                    end
                    else
                    begin
                        expect_b64(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
                        expect_b64(b64_symbol({b1[3:0], 2'b00}), 1'b0);
                    end
                    expect_b64(h2b_pkg::PAD_CHAR, 1'b1);
                end
            end
            if (lst)
            begin
                enc_group_cnt = 2'd0;
                enc_group[0]  = 8'h00;
                enc_group[1]  = 8'h00;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_hex_char(input logic [7:0] c, input logic lst);
        hex_beat_t beat;
        beat.ch   = c;
        beat.last = lst;
        hex_pending.push_back(beat);
    endtask

    // Queues a whole stream, with last set on its final character.
    task automatic add_stream(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_hex_char(s[i], i == s.len() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers beats at the falling edge, in bursts with gaps between
    // them. A beat that is offered stays on the port until it is taken.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && !beat_taken)
            begin
                // Still waiting for the unit to take the current beat.
            end
            else if (hex_pending.size() > 0 && (hold_off || burst_left > 0))
            begin
                push    <= 1'b1;
                hex_char <= hex_pending[0].ch;
                last_in <= hex_pending[0].last;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                push <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                end
                else
                begin
                    // Mostly short bursts, sometimes a long unbroken run.
                    burst_left = ($urandom_range(0, 3) == 0) ?
                                 $urandom_range(30, 80) : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: sets pop at the falling edge on a stall pattern that changes
    // after a random number of cycles.
    // ------------------------------------------------------------------------
    pop_mode_t pop_mode = POP_ALWAYS;
    int        mode_left = 0;

    always @(negedge clk)
    begin
        logic take;
        take = 1'b1;
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                pop_mode  = pop_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 40);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (pop_mode)
                POP_ALWAYS: take = 1'b1;
                POP_HALF:   take = $urandom_range(0, 1) == 1;
                POP_SPARSE: take = $urandom_range(0, 3) == 0;
                default:    take = $urandom_range(0, 6) != 0;
            endcase
            pop <= take && !hold_off;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, an input beat that is taken runs through
    // the model, and an output beat that is taken is checked against the
    // oldest expected character.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic      in_beat;
        hex_beat_t sent;
        b64_beat_t want;
        in_beat = push && !full;
        if (rst_n)
        begin
            beat_taken <= in_beat;
            if (in_beat)
            begin
                sent = hex_pending.pop_front();
                encode_hex_char(sent.ch, sent.last);
                hex_accepted = hex_accepted + 1;
            end
            if (pop && !empty)
            begin
                if (b64_expected.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: unexpected beat: expected none, actual char %h last %b",
                             $time, b64_char, last_out);
                end
                else
                begin
                    want = b64_expected.pop_front();
                    if (b64_char !== want.ch)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t: b64_char mismatch: expected %h, actual %h",
                                 $time, want.ch, b64_char);
                    end
                    if (last_out !== want.last)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t: last_out mismatch: expected %b, actual %b",
                                 $time, want.last, last_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off. Once traffic is flowing, the receiver stops
    // popping for a long stretch while the driver keeps offering beats, so
    // the group queue fills and full must hold off the sender.
    // ------------------------------------------------------------------------
    initial
    begin
        while (hex_accepted < 30)
        begin
            @(posedge clk);
        end
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int         target;
        int         len;
        logic [7:0] c;

        // Directed streams. Digit extremes, a full group at the end, two and
        // one leftover bytes, a single odd character, and an odd stream.
        add_stream("09afAF");
        add_stream("4d61");
        add_stream("4d");
        add_stream("F");
        add_stream("abc");
        // Codes just outside the digit ranges and the byte extremes, all of
        // which decode to zero.
        add_hex_char(8'hFF, 1'b0);
        add_hex_char(8'h00, 1'b0);
        add_hex_char(8'h2F, 1'b0);
        add_hex_char(8'h3A, 1'b0);
        add_hex_char(8'h40, 1'b0);
        add_hex_char(8'h47, 1'b0);
        add_hex_char(8'h60, 1'b0);
        add_hex_char(8'h67, 1'b1);

        // Random well-formed streams of random length, mostly hex digits
        // with some arbitrary bytes mixed in.
        target = hex_pending.size() + RANDOM_ITEMS;
        while (hex_pending.size() < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                else
                begin
                    c = hex_digits[$urandom_range(0, hex_digits.len() - 1)];
                end
                add_hex_char(c, i == len - 1);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (hex_pending.size() != 0)
        begin
            @(posedge clk);
        end
        while (b64_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // A few more cycles so that any stray extra beat would show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && b64_expected.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
